### hw/rtl/crt_pkg.sv
// ---------------------------------------------------------------------------
// crt_pkg
// shared constants, register indexes and sequencer states for the residue
// reconstruction block
// ---------------------------------------------------------------------------
`default_nettype none

package crt_pkg;

    // fixed by the residue and result fields
    localparam int NUM_MODULI     = 5;
    localparam int MODULUS_BITS   = 7;
    localparam int VALUE_BITS     = 35;
    localparam int COUNT_BITS     = 3;
    localparam int CFG_INDEX_BITS = $clog2(NUM_MODULI + 1);

    // register stages inside one lane
    localparam int LANE_STAGES = 5;

    // register indexes
    localparam int CFG_COUNT     = 0;
    localparam int CFG_MODULUS_0 = 1;

    localparam int COUNT_RESET = 5;

    typedef enum logic [2:0] {
        PC_PROD,
        PC_QMOD,
        PC_INV,
        PC_RECIP,
        PC_STORE,
        PC_DONE
    } t_pc_state;

    function automatic int reset_modulus(input int idx);
        int val;
        case (idx)
            0:       val = 2;
            1:       val = 3;
            2:       val = 5;
            3:       val = 7;
            4:       val = 11;
            default: val = 1;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/crt_residue_reconstruct.sv
// an input beat passes through the lane stages and then the adder chain to the result beat
// throughput: one beat per cycle unless the sequencer is busy or the result beat is held
// back; every stage holds one item and advances together
// after reset and after every register write a sequencer derives per-modulus constants,
// mostly in the inverse search per modulus; o_stall stays high for that time
// reset is synchronous and active low; registers return to count 5, moduli 2 3 5 7 11
// ---------------------------------------------------------------------------
// crt_residue_reconstruct
// chinese remainder reconstruction of an integer from its residues
// ---------------------------------------------------------------------------
`default_nettype none

module crt_residue_reconstruct #(
    parameter int MODULUS_BITS = crt_pkg::MODULUS_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input beats
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [MODULUS_BITS-1:0]             i_residue_0,
    input  wire logic [MODULUS_BITS-1:0]             i_residue_1,
    input  wire logic [MODULUS_BITS-1:0]             i_residue_2,
    input  wire logic [MODULUS_BITS-1:0]             i_residue_3,
    input  wire logic [MODULUS_BITS-1:0]             i_residue_4,
    // result beats
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [crt_pkg::VALUE_BITS-1:0]           o_value,
    // register writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [crt_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [((MODULUS_BITS > crt_pkg::COUNT_BITS) ? MODULUS_BITS
                        : crt_pkg::COUNT_BITS)-1:0]  i_cfg_data
);

    localparam int NM  = crt_pkg::NUM_MODULI;
    localparam int MB  = MODULUS_BITS;
    localparam int PW  = NM * MB;
    localparam int IW  = $clog2(NM + 1);
    localparam int LAT = crt_pkg::LANE_STAGES + NM;

    // configuration registers
    logic [crt_pkg::COUNT_BITS-1:0] r_count;
    logic [MB-1:0]                  r_modulus [NM];
    logic                           w_cfg_wr;

    // effective view: zero modulus acts as one, count clamped to 1..NM
    logic [MB-1:0] w_modulus [NM];
    logic [IW-1:0] w_count;

    // constants from the sequencer
    logic          w_busy;
    logic [MB-1:0] w_coef     [NM];
    logic [2*MB:0] w_recip    [NM];
    logic [PW-1:0] w_cofactor [NM];
    logic [PW-1:0] w_product;

    // datapath
    logic [MB-1:0] w_residue [NM];
    logic [PW-1:0] w_term    [NM];
    logic [PW-1:0] w_sum;

    // valid bits travelling alongside the stages
    logic [LAT-1:0] r_vld;
    logic           w_adv;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= crt_pkg::COUNT_BITS'(crt_pkg::COUNT_RESET);
            for (int i = 0; i < NM; i++) begin
                r_modulus[i] <= MB'(crt_pkg::reset_modulus(i));
            end
        end else if (w_cfg_wr) begin
            if (i_cfg_index == crt_pkg::CFG_INDEX_BITS'(crt_pkg::CFG_COUNT)) begin
                r_count <= i_cfg_data[crt_pkg::COUNT_BITS-1:0];
            end
            // writes beyond the last modulus fall through untouched
            for (int i = 0; i < NM; i++) begin
                if (i_cfg_index == crt_pkg::CFG_INDEX_BITS'(crt_pkg::CFG_MODULUS_0 + i)) begin
                    r_modulus[i] <= i_cfg_data[MB-1:0];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NM; i++) begin
            w_modulus[i] = (r_modulus[i] == '0) ? MB'(1) : r_modulus[i];
        end
        if (r_count == '0) begin
            w_count = IW'(1);
        end else if (r_count > crt_pkg::COUNT_BITS'(NM)) begin
            w_count = IW'(NM);
        end else begin
            w_count = IW'(r_count);
        end
    end

    // constants are rebuilt after reset and whenever a register changes
    crt_precompute #(
        .MB (MB),
        .PW (PW)
    ) u_precompute (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cfg_wr),
        .i_modulus  (w_modulus),
        .i_count    (w_count),
        .o_busy     (w_busy),
        .o_coef     (w_coef),
        .o_recip    (w_recip),
        .o_cofactor (w_cofactor),
        .o_product  (w_product)
    );

    // whole pipe advances unless the result beat is held back
    assign w_adv   = !(r_vld[LAT-1] && i_stall);
    assign o_stall = w_busy || !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid && !w_busy};
        end
    end

    assign w_residue[0] = i_residue_0;
    assign w_residue[1] = i_residue_1;
    assign w_residue[2] = i_residue_2;
    assign w_residue[3] = i_residue_3;
    assign w_residue[4] = i_residue_4;

    // one lane per modulus, all in lock step
    for (genvar i = 0; i < NM; i++) begin : g_lane
        crt_lane #(
            .MB (MB),
            .PW (PW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_adv      (w_adv),
            .i_residue  (w_residue[i]),
            .i_coef     (w_coef[i]),
            .i_recip    (w_recip[i]),
            .i_modulus  (w_modulus[i]),
            .i_cofactor (w_cofactor[i]),
            .o_term     (w_term[i])
        );
    end

    // terms summed modulo the full product
    crt_accum #(
        .PW (PW)
    ) u_accum (
        .i_clk     (i_clk),
        .i_adv     (w_adv),
        .i_term    (w_term),
        .i_product (w_product),
        .o_sum     (w_sum)
    );

    assign o_valid = r_vld[LAT-1];
    assign o_value = crt_pkg::VALUE_BITS'(w_sum);

    // a register write restarts the sequencer
    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> w_busy)
        else $error("sequencer not restarted after register write");

    // a result beat is always reduced below the product
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_sum < w_product))
        else $error("result not reduced modulo product");

    // an advancing pipe hands the second-to-last valid bit to the output
    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[LAT-2]) |=> o_valid)
        else $error("item lost between last stages");

endmodule

`default_nettype wire

### hw/rtl/crt_precompute.sv
// ---------------------------------------------------------------------------
// crt_precompute
// sequencer that derives per-modulus cofactors, inverses and reciprocals, and the full product
// ---------------------------------------------------------------------------
`default_nettype none

module crt_precompute #(
    parameter int MB = crt_pkg::MODULUS_BITS,
    parameter int PW = crt_pkg::NUM_MODULI * crt_pkg::MODULUS_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [MB-1:0]         i_modulus [crt_pkg::NUM_MODULI],
    input  wire logic [$clog2(crt_pkg::NUM_MODULI+1)-1:0] i_count,
    output logic                       o_busy,
    output logic [MB-1:0]              o_coef     [crt_pkg::NUM_MODULI],
    output logic [2*MB:0]              o_recip    [crt_pkg::NUM_MODULI],
    output logic [PW-1:0]              o_cofactor [crt_pkg::NUM_MODULI],
    output logic [PW-1:0]              o_product
);

    localparam int NM      = crt_pkg::NUM_MODULI;
    localparam int K       = 2 * MB;
    localparam int IW      = $clog2(NM + 1);
    localparam int JW      = (NM > 1) ? $clog2(NM) : 1;
    localparam int BIT_MAX = ((PW - 1) > K) ? (PW - 1) : K;
    localparam int CW      = $clog2(BIT_MAX + 1);

    crt_pkg::t_pc_state r_state, n_state;

    logic [IW-1:0] r_i,   n_i;
    logic [JW-1:0] r_j,   n_j;
    logic [PW-1:0] r_acc, n_acc;
    logic [PW-1:0] r_sh,  n_sh;
    logic [CW-1:0] r_bit, n_bit;
    logic [MB:0]   r_rem, n_rem;
    logic [K:0]    r_quo, n_quo;
    logic [MB-1:0] r_a,   n_a;
    logic [MB-1:0] r_t,   n_t;
    logic [MB-1:0] r_k,   n_k;
    logic [MB-1:0] r_inv, n_inv;

    logic [MB-1:0] w_mi;
    logic [MB-1:0] w_mj;
    logic          w_use_j;
    logic [MB:0]   w_shift;
    logic [MB:0]   w_red;
    logic          w_qbit;
    logic [MB:0]   w_sum;
    logic [MB-1:0] w_tn;
    logic          w_inv_done;

    assign w_mi    = (r_i < IW'(NM)) ? i_modulus[r_i[JW-1:0]] : MB'(1);
    assign w_mj    = i_modulus[r_j];
    assign w_use_j = (IW'(r_j) < i_count) && (IW'(r_j) != r_i);

    // one bit of restoring division per cycle
    assign w_shift = (r_state == crt_pkg::PC_QMOD)
                   ? {r_rem[MB-1:0], r_sh[PW-1]}
                   : {r_rem[MB-1:0], (r_bit == CW'(K))};
    assign w_qbit  = (w_shift >= {1'b0, w_mi});
    assign w_red   = w_qbit ? (w_shift - {1'b0, w_mi}) : w_shift;

    // running multiple of the cofactor residue for the inverse search
    assign w_sum      = {1'b0, r_t} + {1'b0, r_a};
    assign w_tn       = (w_sum >= {1'b0, w_mi}) ? MB'(w_sum - {1'b0, w_mi})
                                                 : w_sum[MB-1:0];
    assign w_inv_done = (w_mi <= MB'(1)) || (r_k == MB'(w_mi - MB'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crt_pkg::PC_PROD: begin
                if (r_j == JW'(NM - 1)) begin
                    n_state = (r_i == IW'(NM)) ? crt_pkg::PC_STORE : crt_pkg::PC_QMOD;
                end
            end
            crt_pkg::PC_QMOD: begin
                if (r_bit == '0) begin
                    n_state = crt_pkg::PC_INV;
                end
            end
            crt_pkg::PC_INV: begin
                if (w_inv_done) begin
                    n_state = crt_pkg::PC_RECIP;
                end
            end
            crt_pkg::PC_RECIP: begin
                if (r_bit == '0) begin
                    n_state = crt_pkg::PC_STORE;
                end
            end
            crt_pkg::PC_STORE: begin
                n_state = (r_i == IW'(NM)) ? crt_pkg::PC_DONE : crt_pkg::PC_PROD;
            end
            crt_pkg::PC_DONE: begin
                n_state = crt_pkg::PC_DONE;
            end
            default: begin
                n_state = crt_pkg::PC_DONE;
            end
        endcase
        if (i_start) begin
            n_state = crt_pkg::PC_PROD;
        end
    end

    // datapath
    always_comb begin
        n_i   = r_i;
        n_j   = r_j;
        n_acc = r_acc;
        n_sh  = r_sh;
        n_bit = r_bit;
        n_rem = r_rem;
        n_quo = r_quo;
        n_a   = r_a;
        n_t   = r_t;
        n_k   = r_k;
        n_inv = r_inv;
        unique case (r_state)
            crt_pkg::PC_PROD: begin
                if (w_use_j) begin
                    n_acc = r_acc * PW'(w_mj);
                end
                n_j   = r_j + JW'(1);
                n_sh  = n_acc;
                n_bit = CW'(PW - 1);
                n_rem = '0;
            end
            crt_pkg::PC_QMOD: begin
                n_sh  = {r_sh[PW-2:0], 1'b0};
                n_rem = w_red;
                n_bit = r_bit - CW'(1);
                n_a   = w_red[MB-1:0];
                n_t   = '0;
                n_k   = MB'(1);
                n_inv = '0;
            end
            crt_pkg::PC_INV: begin
                n_t = w_tn;
                n_k = r_k + MB'(1);
                if ((w_mi > MB'(1)) && (w_tn == MB'(1))) begin
                    n_inv = r_k;
                end
                n_bit = CW'(K);
                n_rem = '0;
                n_quo = '0;
            end
            crt_pkg::PC_RECIP: begin
                n_rem = w_red;
                n_quo = {r_quo[K-1:0], w_qbit};
                n_bit = r_bit - CW'(1);
            end
            crt_pkg::PC_STORE: begin
                n_i   = r_i + IW'(1);
                n_j   = '0;
                n_acc = PW'(1);
            end
            crt_pkg::PC_DONE: begin
                n_i = r_i;
            end
            default: begin
                n_i = r_i;
            end
        endcase
        if (i_start) begin
            n_i   = '0;
            n_j   = '0;
            n_acc = PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crt_pkg::PC_PROD;
            r_i     <= '0;
            r_j     <= '0;
            r_acc   <= PW'(1);
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh  <= n_sh;
        r_bit <= n_bit;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_a   <= n_a;
        r_t   <= n_t;
        r_k   <= n_k;
        r_inv <= n_inv;
    end

    // results; lanes beyond the count in use get zero inverse and cofactor
    always_ff @(posedge i_clk) begin
        if (r_state == crt_pkg::PC_STORE) begin
            if (r_i == IW'(NM)) begin
                o_product <= r_acc;
            end else begin
                o_coef[r_i[JW-1:0]]     <= (r_i < i_count) ? r_inv : '0;
                o_cofactor[r_i[JW-1:0]] <= (r_i < i_count) ? r_acc : '0;
                o_recip[r_i[JW-1:0]]    <= r_quo;
            end
        end
    end

    assign o_busy = (r_state != crt_pkg::PC_DONE);

endmodule

`default_nettype wire

### hw/rtl/crt_lane.sv
// ---------------------------------------------------------------------------
// crt_lane
// per-modulus pipeline: residue times inverse, reduction, times cofactor
// ---------------------------------------------------------------------------
`default_nettype none

module crt_lane #(
    parameter int MB = crt_pkg::MODULUS_BITS,
    parameter int PW = crt_pkg::NUM_MODULI * crt_pkg::MODULUS_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_adv,
    input  wire logic [MB-1:0] i_residue,
    input  wire logic [MB-1:0] i_coef,
    input  wire logic [2*MB:0] i_recip,
    input  wire logic [MB-1:0] i_modulus,
    input  wire logic [PW-1:0] i_cofactor,
    output logic      [PW-1:0] o_term
);

    localparam int K = 2 * MB;

    logic [K-1:0]  r_x1;
    logic [K-1:0]  r_x2;
    logic [2*K:0]  r_y;
    logic [MB:0]   r_rem;
    logic [MB-1:0] r_coef;
    logic [PW-1:0] r_term;

    logic [K-1:0]  w_x;
    logic [K-1:0]  w_qest;
    logic [K-1:0]  w_qm;

    assign w_x    = K'(i_residue) * K'(i_coef);
    // estimate is exact or one low
    assign w_qest = r_y[2*K-1:K];
    assign w_qm   = w_qest * K'(i_modulus);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x1   <= w_x;
            r_x2   <= r_x1;
            r_y    <= (2*K+1)'(r_x1) * (2*K+1)'(i_recip);
            r_rem  <= (MB+1)'(r_x2 - w_qm);
            r_coef <= (r_rem >= {1'b0, i_modulus}) ? MB'(r_rem - {1'b0, i_modulus})
                                                   : r_rem[MB-1:0];
            r_term <= PW'(r_coef) * i_cofactor;
        end
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

### hw/rtl/crt_accum.sv
// ---------------------------------------------------------------------------
// crt_accum
// chain of modular adders, one term folded in per stage
// ---------------------------------------------------------------------------
`default_nettype none

module crt_accum #(
    parameter int PW = crt_pkg::NUM_MODULI * crt_pkg::MODULUS_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_adv,
    input  wire logic [PW-1:0] i_term [crt_pkg::NUM_MODULI],
    input  wire logic [PW-1:0] i_product,
    output logic      [PW-1:0] o_sum
);

    localparam int NM = crt_pkg::NUM_MODULI;

    logic [PW-1:0] r_acc [NM];
    logic [PW-1:0] r_tm  [NM][NM];
    logic [PW-1:0] w_acc_in [NM];
    logic [PW-1:0] w_tm_in  [NM][NM];
    logic [PW:0]   w_sum    [NM];
    logic [PW-1:0] w_red    [NM];

    for (genvar k = 0; k < NM; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_acc_in[k] = '0;
            assign w_tm_in[k]  = i_term;
        end else begin : g_next
            assign w_acc_in[k] = r_acc[k-1];
            assign w_tm_in[k]  = r_tm[k-1];
        end

        // both operands below the product, so one subtract suffices
        assign w_sum[k] = (PW+1)'(w_acc_in[k]) + (PW+1)'(w_tm_in[k][k]);
        assign w_red[k] = (w_sum[k] >= (PW+1)'(i_product))
                        ? PW'(w_sum[k] - (PW+1)'(i_product)) : w_sum[k][PW-1:0];

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_acc[k] <= w_red[k];
                r_tm[k]  <= w_tm_in[k];
            end
        end
    end

    assign o_sum = r_acc[NM-1];

endmodule

`default_nettype wire
